// ===== design/ugns_pkg.sv =====
// Shared types, constants and neighbour tables of the uniform grid neighbour store.
package ugns_pkg;

	localparam int GRID_DIM   = 16;
	localparam int CELL_SLOTS = 4;

	localparam int NCELLS = GRID_DIM * GRID_DIM;
	localparam int CW     = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
	localparam int CIW    = $clog2(NCELLS);
	localparam int SAW    = $clog2(NCELLS * CELL_SLOTS);
	localparam int FW     = $clog2(CELL_SLOTS + 1);
	localparam int IDW    = 16;
	localparam int POSW   = 16;
	localparam int MAGW   = POSW - 1;
	localparam int CPW    = 13;
	localparam int OCW    = 6;

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_MOVE   = 3'd2;
	localparam logic [2:0] OP_QUERY  = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	localparam logic [CPW-1:0] CELL_PIXELS_RESET = CPW'(64);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV_GO,
		S_DIV_WAIT,
		S_CELL,
		S_FILL,
		S_SLOT_RD,
		S_SLOT_WT,
		S_SCAN_END,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		PH_ADD,
		PH_REMOVE,
		PH_QUERY
	} phase_t;

	typedef logic signed [1:0] off_t;

	// Neighbour offsets per region; region = row class * 3 + column class.
	localparam logic [3:0] NB_CNT [9] = '{4'd3, 4'd5, 4'd3, 4'd5, 4'd8, 4'd5, 4'd3, 4'd5, 4'd3};
	localparam off_t NB_DX [9][8] = '{
		'{ 1,  1,  0,  0,  0,  0,  0,  0},
		'{ 1,  1,  0, -1, -1,  0,  0,  0},
		'{-1, -1,  0,  0,  0,  0,  0,  0},
		'{ 0,  1,  1,  0,  1,  0,  0,  0},
		'{-1,  0,  1, -1,  1,  0, -1,  1},
		'{ 0, -1, -1,  0, -1,  0,  0,  0},
		'{ 0,  1,  1,  0,  0,  0,  0,  0},
		'{-1, -1,  0,  1,  1,  0,  0,  0},
		'{-1, -1,  0,  0,  0,  0,  0,  0}
	};
	localparam off_t NB_DY [9][8] = '{
		'{ 0,  1,  1,  0,  0,  0,  0,  0},
		'{ 0,  1,  1,  1,  0,  0,  0,  0},
		'{ 0,  1,  1,  0,  0,  0,  0,  0},
		'{-1, -1,  0,  1,  1,  0,  0,  0},
		'{-1, -1, -1,  0,  0,  1,  1,  1},
		'{-1, -1,  0,  1,  1,  0,  0,  0},
		'{-1, -1,  0,  0,  0,  0,  0,  0},
		'{ 0, -1, -1, -1,  0,  0,  0,  0},
		'{ 0, -1, -1,  0,  0,  0,  0,  0}
	};

	typedef struct packed {
		logic            fill_re;
		logic            fill_we;
		logic            clear;
		logic [CIW-1:0]  cell_idx;
		logic [FW-1:0]   fill_wdata;
		logic            slot_re;
		logic            slot_we;
		logic [SAW-1:0]  slot_addr;
		logic [IDW-1:0]  slot_wdata;
	} mem_req_t;

	typedef struct packed {
		logic            valid;
		logic [IDW-1:0]  found_id;
		logic [CW-1:0]   cell_x;
		logic [CW-1:0]   cell_y;
		logic            id_valid;
		logic            status;
		logic            last;
	} out_item_t;

	function automatic logic [1:0] edge_class(input logic [CW-1:0] v);
		if (v == '0) begin
			return 2'd0;
		end else if (v == CW'(GRID_DIM - 1)) begin
			return 2'd2;
		end
		return 2'd1;
	endfunction

	function automatic logic [3:0] region_of(input logic [CW-1:0] x, input logic [CW-1:0] y);
		return 4'(edge_class(y) * 3 + edge_class(x));
	endfunction

endpackage

// ===== design/uniform_grid_neighbour_store_core.sv =====
// Top level of the uniform grid neighbour store: configuration, output register and wiring.
//
// The block keeps, for each cell of a square grid, an ordered list of entity ids, and serves
// add, remove, move, near query and clear operations one at a time; in_ready is high only
// while no operation is in progress. Each position is turned into a cell by a shared
// restoring divider that produces one quotient bit per cycle; add, remove and query convert
// two coordinates and move converts four. After that a small sequencer reads the fill count
// of a cell, then every stored id through the registered slot memory, and then closes the
// cell; a move walks the old and then the new cell, and a query the home cell and each
// neighbour, waiting wherever the result consumer stalls. Clear and unknown operations go
// straight to the final result; clear drops every fill valid bit at once, so there is no
// clearing pass after reset. Each result is held in an output register, so a transfer on
// the output side never stalls the sequencer longer than the consumer takes. The cell size
// must be written through cfg_we and cfg_wdata only while the block is idle, by the user;
// the block itself does not enforce this. Zero acts as one.
module uniform_grid_neighbour_store_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ugns_pkg::CPW-1:0]      cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    operation,
	input  logic [ugns_pkg::IDW-1:0]      entity_id,
	input  logic signed [ugns_pkg::POSW-1:0] pos_x,
	input  logic signed [ugns_pkg::POSW-1:0] pos_y,
	input  logic signed [ugns_pkg::POSW-1:0] old_pos_x,
	input  logic signed [ugns_pkg::POSW-1:0] old_pos_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ugns_pkg::IDW-1:0]      found_id,
	output logic [ugns_pkg::OCW-1:0]      cell_x,
	output logic [ugns_pkg::OCW-1:0]      cell_y,
	output logic                          id_valid,
	output logic                          status,
	output logic                          last
);

	logic [ugns_pkg::CPW-1:0]  cell_pixels_q;
	logic                      out_valid_q;
	ugns_pkg::out_item_t       out_q;
	ugns_pkg::out_item_t       push;
	ugns_pkg::mem_req_t        req;
	logic                      out_free;
	logic [ugns_pkg::FW-1:0]   fill_rd;
	logic [ugns_pkg::IDW-1:0]  slot_rd;

	// The output register can take a new result when it is empty or its transfer completes now.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_pixels_q <= ugns_pkg::CELL_PIXELS_RESET;
		end else if (cfg_we) begin
			cell_pixels_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The payload needs no reset; it is only looked at while out_valid is high.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			out_q <= push;
		end
	end

	ugns_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.entity_id   (entity_id),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.old_pos_x   (old_pos_x),
		.old_pos_y   (old_pos_y),
		.cell_pixels (cell_pixels_q),
		.out_free    (out_free),
		.push        (push),
		.req         (req),
		.fill_rd     (fill_rd),
		.slot_rd     (slot_rd)
	);

	ugns_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.fill_rd (fill_rd),
		.slot_rd (slot_rd)
	);

	assign out_valid = out_valid_q;
	assign found_id  = out_q.found_id;
	assign cell_x    = ugns_pkg::OCW'(out_q.cell_x);
	assign cell_y    = ugns_pkg::OCW'(out_q.cell_y);
	assign id_valid  = out_q.id_valid;
	assign status    = out_q.status;
	assign last      = out_q.last;

endmodule

// ===== design/ugns_div.sv =====
// Restoring divider, one quotient bit per cycle, for pixel to cell conversion.
module ugns_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ugns_pkg::MAGW-1:0]     dividend,
	input  logic [ugns_pkg::CPW-1:0]      divisor,
	output logic                          done,
	output logic [ugns_pkg::MAGW-1:0]     quotient
);

	logic [ugns_pkg::CPW-1:0]  rem_q;
	logic [ugns_pkg::MAGW-1:0] quo_q;
	logic [3:0]                cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [ugns_pkg::CPW-1:0]  dv;
	logic [ugns_pkg::CPW:0]    sh;
	logic                      ge;

	// A zero cell size behaves as one.
	assign dv = (divisor == '0) ? ugns_pkg::CPW'(1) : divisor;
	assign sh = {rem_q, quo_q[ugns_pkg::MAGW-1]};
	assign ge = sh >= {1'b0, dv};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(ugns_pkg::MAGW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? ugns_pkg::CPW'(sh - {1'b0, dv}) : sh[ugns_pkg::CPW-1:0];
			quo_q <= {quo_q[ugns_pkg::MAGW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/ugns_store.sv =====
// Cell fill counts with valid bits and the slot memory holding the ids of every cell.
module ugns_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ugns_pkg::mem_req_t            req,
	output logic [ugns_pkg::FW-1:0]       fill_rd,
	output logic [ugns_pkg::IDW-1:0]      slot_rd
);

	logic [ugns_pkg::FW-1:0]  fill_mem [ugns_pkg::NCELLS];
	logic [ugns_pkg::IDW-1:0] slot_mem [ugns_pkg::NCELLS * ugns_pkg::CELL_SLOTS];
	logic [ugns_pkg::NCELLS-1:0] valid_q;
	logic [ugns_pkg::FW-1:0]  fill_rd_q;
	logic [ugns_pkg::IDW-1:0] slot_rd_q;

	// A cell whose valid bit is low reads as empty; clear drops every valid bit at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clear) begin
			valid_q <= '0;
		end else if (req.fill_we) begin
			valid_q[req.cell_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.fill_we) begin
			fill_mem[req.cell_idx] <= req.fill_wdata;
		end
		if (req.fill_re) begin
			fill_rd_q <= valid_q[req.cell_idx] ? fill_mem[req.cell_idx] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.slot_we) begin
			slot_mem[req.slot_addr] <= req.slot_wdata;
		end
		if (req.slot_re) begin
			slot_rd_q <= slot_mem[req.slot_addr];
		end
	end

	assign fill_rd = fill_rd_q;
	assign slot_rd = slot_rd_q;

endmodule

// ===== design/ugns_seq.sv =====
// Sequencer that converts positions, walks cells and slots, and hands results onwards.
module ugns_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    operation,
	input  logic [ugns_pkg::IDW-1:0]      entity_id,
	input  logic [ugns_pkg::POSW-1:0]     pos_x,
	input  logic [ugns_pkg::POSW-1:0]     pos_y,
	input  logic [ugns_pkg::POSW-1:0]     old_pos_x,
	input  logic [ugns_pkg::POSW-1:0]     old_pos_y,
	input  logic [ugns_pkg::CPW-1:0]      cell_pixels,
	input  logic                          out_free,
	output ugns_pkg::out_item_t           push,
	output ugns_pkg::mem_req_t            req,
	input  logic [ugns_pkg::FW-1:0]       fill_rd,
	input  logic [ugns_pkg::IDW-1:0]      slot_rd
);

	localparam int CW  = ugns_pkg::CW;
	localparam int FW  = ugns_pkg::FW;
	localparam int CIW = ugns_pkg::CIW;
	localparam int SAW = ugns_pkg::SAW;

	ugns_pkg::state_t state_q, state_d;
	ugns_pkg::phase_t phase_q;

	logic [2:0]                   op_q;
	logic [ugns_pkg::IDW-1:0]     id_q;
	logic [ugns_pkg::POSW-1:0]    coord_q [4];
	logic [1:0]                   dsel_q;
	logic [CW-1:0]                cx_q, cy_q, ox_q;
	logic [CW-1:0]                cur_x_q, cur_y_q;
	logic [FW-1:0]                n_q, i_q, w_q;
	logic                         found_q;
	logic                         status_q;
	logic [3:0]                   k_q;
	logic                         pend_valid_q;
	logic [ugns_pkg::IDW-1:0]     pend_id_q;
	logic [CW-1:0]                pend_x_q, pend_y_q;

	logic                         div_start, div_done;
	logic [ugns_pkg::MAGW-1:0]    quotient;
	logic [ugns_pkg::POSW-1:0]    coord_sel;
	logic [CW-1:0]                cell_q;
	logic [1:0]                   dsel_last;
	logic [CIW-1:0]               cur_cell;
	logic [3:0]                   region;
	logic [2:0]                   nb;
	logic                         scan_more;
	logic                         query_stall;

	assign coord_sel = coord_q[dsel_q];
	assign dsel_last = (op_q == ugns_pkg::OP_MOVE) ? 2'd3 : 2'd1;
	assign cur_cell  = CIW'(cur_x_q) * CIW'(ugns_pkg::GRID_DIM) + CIW'(cur_y_q);
	assign region    = ugns_pkg::region_of(cx_q, cy_q);
	assign nb        = k_q[2:0];
	assign scan_more = (i_q + FW'(1)) < n_q;
	assign query_stall = (phase_q == ugns_pkg::PH_QUERY) && pend_valid_q && !out_free;

	// Truncating division then clamping; a negative position always lands in cell zero.
	always_comb begin
		if (coord_sel[ugns_pkg::POSW-1]) begin
			cell_q = '0;
		end else if (quotient > ugns_pkg::MAGW'(ugns_pkg::GRID_DIM - 1)) begin
			cell_q = CW'(ugns_pkg::GRID_DIM - 1);
		end else begin
			cell_q = quotient[CW-1:0];
		end
	end

	ugns_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (coord_sel[ugns_pkg::MAGW-1:0]),
		.divisor  (cell_pixels),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ugns_pkg::S_IDLE: begin
				if (in_valid) begin
					if (operation == ugns_pkg::OP_ADD || operation == ugns_pkg::OP_REMOVE ||
					    operation == ugns_pkg::OP_MOVE || operation == ugns_pkg::OP_QUERY) begin
						state_d = ugns_pkg::S_DIV_GO;
					end else begin
						state_d = ugns_pkg::S_FINISH;
					end
				end
			end
			ugns_pkg::S_DIV_GO:   state_d = ugns_pkg::S_DIV_WAIT;
			ugns_pkg::S_DIV_WAIT: begin
				if (div_done) begin
					state_d = (dsel_q == dsel_last) ? ugns_pkg::S_CELL : ugns_pkg::S_DIV_GO;
				end
			end
			ugns_pkg::S_CELL:     state_d = ugns_pkg::S_FILL;
			ugns_pkg::S_FILL: begin
				state_d = (fill_rd == '0) ? ugns_pkg::S_SCAN_END : ugns_pkg::S_SLOT_RD;
			end
			ugns_pkg::S_SLOT_RD:  state_d = ugns_pkg::S_SLOT_WT;
			ugns_pkg::S_SLOT_WT: begin
				if (!query_stall) begin
					state_d = scan_more ? ugns_pkg::S_SLOT_RD : ugns_pkg::S_SCAN_END;
				end
			end
			ugns_pkg::S_SCAN_END: begin
				unique case (phase_q)
					ugns_pkg::PH_REMOVE: begin
						state_d = (op_q == ugns_pkg::OP_MOVE) ? ugns_pkg::S_CELL
						                                      : ugns_pkg::S_FINISH;
					end
					ugns_pkg::PH_QUERY: begin
						state_d = (k_q == ugns_pkg::NB_CNT[region]) ? ugns_pkg::S_FINISH
						                                           : ugns_pkg::S_CELL;
					end
					default: state_d = ugns_pkg::S_FINISH;
				endcase
			end
			ugns_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = ugns_pkg::S_IDLE;
				end
			end
			default: state_d = ugns_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ugns_pkg::S_IDLE);
		div_start = (state_q == ugns_pkg::S_DIV_GO);
		req            = '0;
		req.cell_idx   = cur_cell;
		req.slot_addr  = SAW'(cur_cell) * SAW'(ugns_pkg::CELL_SLOTS) + SAW'(i_q);
		req.slot_wdata = slot_rd;
		push           = '0;
		unique case (state_q)
			ugns_pkg::S_IDLE: begin
				req.clear = in_valid && (operation == ugns_pkg::OP_CLEAR);
			end
			ugns_pkg::S_CELL:    req.fill_re = 1'b1;
			ugns_pkg::S_SLOT_RD: req.slot_re = 1'b1;
			ugns_pkg::S_SLOT_WT: begin
				if (phase_q == ugns_pkg::PH_REMOVE && slot_rd != id_q) begin
					req.slot_we   = 1'b1;
					req.slot_addr = SAW'(cur_cell) * SAW'(ugns_pkg::CELL_SLOTS) + SAW'(w_q);
				end
				if (phase_q == ugns_pkg::PH_QUERY && pend_valid_q && out_free) begin
					push.valid    = 1'b1;
					push.found_id = pend_id_q;
					push.cell_x   = pend_x_q;
					push.cell_y   = pend_y_q;
					push.id_valid = 1'b1;
				end
			end
			ugns_pkg::S_SCAN_END: begin
				if (phase_q == ugns_pkg::PH_REMOVE) begin
					req.fill_we    = 1'b1;
					req.fill_wdata = w_q;
				end else if (phase_q == ugns_pkg::PH_ADD && !found_q &&
				             n_q < FW'(ugns_pkg::CELL_SLOTS)) begin
					req.fill_we    = 1'b1;
					req.fill_wdata = n_q + FW'(1);
					req.slot_we    = 1'b1;
					req.slot_addr  = SAW'(cur_cell) * SAW'(ugns_pkg::CELL_SLOTS) + SAW'(n_q);
					req.slot_wdata = id_q;
				end
			end
			ugns_pkg::S_FINISH: begin
				push.valid = out_free;
				push.last  = 1'b1;
				if (op_q == ugns_pkg::OP_QUERY && pend_valid_q) begin
					push.found_id = pend_id_q;
					push.cell_x   = pend_x_q;
					push.cell_y   = pend_y_q;
					push.id_valid = 1'b1;
				end else if (op_q == ugns_pkg::OP_ADD || op_q == ugns_pkg::OP_REMOVE ||
				             op_q == ugns_pkg::OP_MOVE || op_q == ugns_pkg::OP_QUERY) begin
					push.cell_x = cx_q;
					push.cell_y = cy_q;
					push.status = status_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ugns_pkg::S_IDLE;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ugns_pkg::S_IDLE) begin
				pend_valid_q <= 1'b0;
			end else if (state_q == ugns_pkg::S_SLOT_WT && phase_q == ugns_pkg::PH_QUERY &&
			             !query_stall) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ugns_pkg::S_IDLE: begin
				op_q       <= operation;
				id_q       <= entity_id;
				coord_q[0] <= pos_x;
				coord_q[1] <= pos_y;
				coord_q[2] <= old_pos_x;
				coord_q[3] <= old_pos_y;
				dsel_q     <= '0;
				status_q   <= 1'b0;
				k_q        <= '0;
			end
			ugns_pkg::S_DIV_WAIT: begin
				if (div_done) begin
					unique case (dsel_q)
						2'd0: cx_q <= cell_q;
						2'd1: cy_q <= cell_q;
						2'd2: ox_q <= cell_q;
						default: ;
					endcase
					dsel_q <= dsel_q + 2'd1;
					if (dsel_q == dsel_last) begin
						if (op_q == ugns_pkg::OP_MOVE) begin
							phase_q <= ugns_pkg::PH_REMOVE;
							cur_x_q <= ox_q;
							cur_y_q <= cell_q;
						end else begin
							phase_q <= (op_q == ugns_pkg::OP_ADD) ? ugns_pkg::PH_ADD
							         : (op_q == ugns_pkg::OP_REMOVE) ? ugns_pkg::PH_REMOVE
							         : ugns_pkg::PH_QUERY;
							cur_x_q <= cx_q;
							cur_y_q <= cell_q;
						end
					end
				end
			end
			ugns_pkg::S_FILL: begin
				n_q     <= fill_rd;
				i_q     <= '0;
				w_q     <= '0;
				found_q <= 1'b0;
			end
			ugns_pkg::S_SLOT_WT: begin
				if (!query_stall) begin
					i_q <= i_q + FW'(1);
					if (phase_q == ugns_pkg::PH_REMOVE && slot_rd != id_q) begin
						w_q <= w_q + FW'(1);
					end
					if (phase_q == ugns_pkg::PH_ADD && slot_rd == id_q) begin
						found_q <= 1'b1;
					end
					if (phase_q == ugns_pkg::PH_QUERY) begin
						pend_id_q <= slot_rd;
						pend_x_q  <= cur_x_q;
						pend_y_q  <= cur_y_q;
					end
				end
			end
			ugns_pkg::S_SCAN_END: begin
				if (phase_q == ugns_pkg::PH_REMOVE) begin
					phase_q <= ugns_pkg::PH_ADD;
					cur_x_q <= cx_q;
					cur_y_q <= cy_q;
				end else if (phase_q == ugns_pkg::PH_ADD) begin
					status_q <= !found_q && (n_q >= FW'(ugns_pkg::CELL_SLOTS));
				end else begin
					cur_x_q <= cx_q + CW'(ugns_pkg::NB_DX[region][nb]);
					cur_y_q <= cy_q + CW'(ugns_pkg::NB_DY[region][nb]);
					k_q     <= k_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> out_free)
		else $error("result handed on while the output register was occupied");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ugns_pkg::S_IDLE) |-> (!push.valid && !req.fill_we && !req.slot_we))
		else $error("activity while idle");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ugns_pkg::S_SLOT_RD) |-> (i_q < n_q))
		else $error("slot read beyond the fill of the cell");
	a_finish_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ugns_pkg::S_FINISH && out_free) |=> (state_q == ugns_pkg::S_IDLE))
		else $error("final result did not end the operation");
`endif

endmodule

// ===== tb/sv/uniform_grid_neighbour_store_core_test.sv =====
// Testbench for the uniform grid neighbour store core: directed and random operations, self-checked.
module uniform_grid_neighbour_store_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	// Grid geometry as the block is built.
	localparam int DIM   = 16;
	localparam int SLOTS = 4;
	localparam int CYCLE_LIMIT = 600000;

	// Neighbour visiting order for each region (row class * 3 + column class).
	localparam int NBR_CNT [9] = '{3, 5, 3, 5, 8, 5, 3, 5, 3};
	localparam int NBR_DX [9][8] = '{
		'{ 1,  1,  0,  0,  0,  0,  0,  0},
		'{ 1,  1,  0, -1, -1,  0,  0,  0},
		'{-1, -1,  0,  0,  0,  0,  0,  0},
		'{ 0,  1,  1,  0,  1,  0,  0,  0},
		'{-1,  0,  1, -1,  1,  0, -1,  1},
		'{ 0, -1, -1,  0, -1,  0,  0,  0},
		'{ 0,  1,  1,  0,  0,  0,  0,  0},
		'{-1, -1,  0,  1,  1,  0,  0,  0},
		'{-1, -1,  0,  0,  0,  0,  0,  0}
	};
	localparam int NBR_DY [9][8] = '{
		'{ 0,  1,  1,  0,  0,  0,  0,  0},
		'{ 0,  1,  1,  1,  0,  0,  0,  0},
		'{ 0,  1,  1,  0,  0,  0,  0,  0},
		'{-1, -1,  0,  1,  1,  0,  0,  0},
		'{-1, -1, -1,  0,  0,  1,  1,  1},
		'{-1, -1,  0,  1,  1,  0,  0,  0},
		'{-1, -1,  0,  0,  0,  0,  0,  0},
		'{ 0, -1, -1, -1,  0,  0,  0,  0},
		'{ 0, -1, -1,  0,  0,  0,  0,  0}
	};

	typedef struct {
		logic [15:0] id;
		logic [5:0]  cx;
		logic [5:0]  cy;
		logic        idv;
		logic        st;
		logic        lst;
	} grid_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [ugns_pkg::CPW-1:0] cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         operation;
	logic [15:0]        entity_id;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] old_pos_x;
	logic signed [15:0] old_pos_y;
	logic               out_valid;
	logic               out_ready;
	logic [15:0]        found_id;
	logic [5:0]         cell_x;
	logic [5:0]         cell_y;
	logic               id_valid;
	logic               status;
	logic               last;

	// Shadow copy of the grid, the cell size and the results still to arrive.
	int           cell_size;
	int           fill_count [DIM*DIM];
	logic [15:0]  slot_ids [DIM*DIM][SLOTS];
	grid_result_t pending_results [$];

	int           mismatches = 0;
	int           cycle_count = 0;
	int           burst_left;
	int           hold_req_seq;
	int           hold_seen_seq;
	int           hold_left;
	int           stall_mode;
	int           stall_phase;
	// Last position handed to each id of the small pool, so that moves usually hit.
	logic signed [15:0] pool_x [16];
	logic signed [15:0] pool_y [16];

	uniform_grid_neighbour_store_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.entity_id(entity_id), .pos_x(pos_x), .pos_y(pos_y),
		.old_pos_x(old_pos_x), .old_pos_y(old_pos_y),
		.out_valid(out_valid), .out_ready(out_ready), .found_id(found_id),
		.cell_x(cell_x), .cell_y(cell_y), .id_valid(id_valid),
		.status(status), .last(last)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// The run is abandoned if it goes on far beyond any correct duration.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("uniform_grid_neighbour_store_core test failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// ---------------------------------------------------------------------------------------
	// Predictor: a software copy of the grid that mirrors every accepted operation.
	// ---------------------------------------------------------------------------------------

	// Truncating division toward zero, then clamping into the grid.
	function automatic int coord_to_cell(input logic signed [15:0] raw);
		int divisor;
		int q;
		divisor = (cell_size == 0) ? 1 : cell_size;
		q = int'(raw) / divisor;
		if (q < 0) q = 0;
		if (q > DIM - 1) q = DIM - 1;
		return q;
	endfunction

	function automatic int edge_cls(input int v);
		if (v == 0) return 0;
		if (v == DIM - 1) return 2;
		return 1;
	endfunction

	function automatic grid_result_t make_result(input logic [15:0] id, input int cx, input int cy,
			input logic idv, input logic st, input logic lst);
		grid_result_t r;
		r.id = id;
		r.cx = 6'(cx);
		r.cy = 6'(cy);
		r.idv = idv;
		r.st = st;
		r.lst = lst;
		return r;
	endfunction

	task automatic drop_id(input int c, input logic [15:0] id);
		int w;
		w = 0;
		for (int i = 0; i < fill_count[c]; i++) begin
			if (slot_ids[c][i] != id) begin
				slot_ids[c][w] = slot_ids[c][i];
				w++;
			end
		end
		fill_count[c] = w;
	endtask

	// Returns 1 when the cell is already full and the id is dropped.
	function automatic logic insert_id(input int c, input logic [15:0] id);
		for (int i = 0; i < fill_count[c]; i++) begin
			if (slot_ids[c][i] == id) return 1'b0;
		end
		if (fill_count[c] >= SLOTS) return 1'b1;
		slot_ids[c][fill_count[c]] = id;
		fill_count[c]++;
		return 1'b0;
	endfunction

	task automatic list_cell(input int x, input int y);
		int c;
		c = x * DIM + y;
		for (int i = 0; i < fill_count[c]; i++) begin
			pending_results.push_back(make_result(slot_ids[c][i], x, y, 1'b1, 1'b0, 1'b0));
		end
	endtask

	task automatic predict_grid_op(input logic [2:0] op, input logic [15:0] id,
			input logic signed [15:0] px, input logic signed [15:0] py,
			input logic signed [15:0] ox, input logic signed [15:0] oy);
		int x;
		int y;
		int base;
		int rg;
		logic st;
		x = coord_to_cell(px);
		y = coord_to_cell(py);
		case (op)
			ugns_pkg::OP_ADD: begin
				st = insert_id(x * DIM + y, id);
				pending_results.push_back(make_result(16'd0, x, y, 1'b0, st, 1'b1));
			end
			ugns_pkg::OP_REMOVE: begin
				drop_id(x * DIM + y, id);
				pending_results.push_back(make_result(16'd0, x, y, 1'b0, 1'b0, 1'b1));
			end
			ugns_pkg::OP_MOVE: begin
				drop_id(coord_to_cell(ox) * DIM + coord_to_cell(oy), id);
				st = insert_id(x * DIM + y, id);
				pending_results.push_back(make_result(16'd0, x, y, 1'b0, st, 1'b1));
			end
			ugns_pkg::OP_QUERY: begin
				base = pending_results.size();
				rg = edge_cls(y) * 3 + edge_cls(x);
				list_cell(x, y);
				for (int i = 0; i < NBR_CNT[rg]; i++) begin
					list_cell(x + NBR_DX[rg][i], y + NBR_DY[rg][i]);
				end
				if (pending_results.size() == base) begin
					pending_results.push_back(make_result(16'd0, x, y, 1'b0, 1'b0, 1'b1));
				end else begin
					pending_results[pending_results.size() - 1].lst = 1'b1;
				end
			end
			ugns_pkg::OP_CLEAR: begin
				for (int c = 0; c < DIM * DIM; c++) fill_count[c] = 0;
				pending_results.push_back(make_result(16'd0, 0, 0, 1'b0, 1'b0, 1'b1));
			end
			default: begin
				// Codes above clear leave the grid alone and give one empty result.
				pending_results.push_back(make_result(16'd0, 0, 0, 1'b0, 1'b0, 1'b1));
			end
		endcase
	endtask

	// ---------------------------------------------------------------------------------------
	// Result side: stall pattern, long hold-off on request, and the field-by-field check.
	// ---------------------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_seen_seq <= 0;
			stall_mode <= 0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
			if (hold_seen_seq != hold_req_seq) begin
				// A fresh hold-off has been asked for: refuse transfers for a long stretch.
				hold_seen_seq <= hold_req_seq;
				hold_left <= 400;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= (stall_phase % 7) > 1;
				endcase
			end
		end
	end

	// Every output transfer is compared against the oldest outstanding prediction.
	always @(posedge clk) begin
		grid_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result id %0h cell %0d,%0d",
					found_id, cell_x, cell_y));
			end else begin
				want = pending_results.pop_front();
				if (found_id !== want.id)
					report_mismatch($sformatf("found_id %0h, wanted %0h", found_id, want.id));
				if (cell_x !== want.cx)
					report_mismatch($sformatf("cell_x %0d, wanted %0d", cell_x, want.cx));
				if (cell_y !== want.cy)
					report_mismatch($sformatf("cell_y %0d, wanted %0d", cell_y, want.cy));
				if (id_valid !== want.idv)
					report_mismatch($sformatf("id_valid %0b, wanted %0b", id_valid, want.idv));
				if (status !== want.st)
					report_mismatch($sformatf("status %0b, wanted %0b", status, want.st));
				if (last !== want.lst)
					report_mismatch($sformatf("last %0b, wanted %0b", last, want.lst));
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// Input side.
	// ---------------------------------------------------------------------------------------

	// Offers one operation and returns at the edge where its transfer takes place. The sender
	// works in bursts; between bursts valid usually drops for a random gap. Valid is
	// only lowered when a real gap follows, so it is never lowered and raised in one step.
	task automatic send_grid_op(input logic [2:0] op, input logic [15:0] id,
			input logic signed [15:0] px, input logic signed [15:0] py,
			input logic signed [15:0] ox, input logic signed [15:0] oy);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		entity_id <= id;
		pos_x <= px;
		pos_y <= py;
		old_pos_x <= ox;
		old_pos_y <= oy;
		do @(posedge clk); while (!in_ready);
		predict_grid_op(op, id, px, py, ox, oy);
	endtask

	// Waits until every predicted result has been seen, plus a margin, with valid low.
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// Writes the cell size while the block is idle.
	task automatic write_cell_size(input int value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= ugns_pkg::CPW'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		cell_size = value & 13'h1fff;
		@(posedge clk);
	endtask

	// Pixel position inside a given cell at the current cell size, kept in range.
	function automatic logic signed [15:0] pixel_in_cell(input int c);
		int sz;
		int p;
		sz = (cell_size == 0) ? 1 : cell_size;
		p = c * sz + $urandom_range(0, sz - 1);
		if (p > 32767) p = 32767;
		return 16'(p);
	endfunction

	// Random coordinate: mostly in cells near the edges or the centre, sometimes anything.
	function automatic logic signed [15:0] random_coord();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) return 16'($urandom);
		if (pick < 4) return pixel_in_cell($urandom_range(0, 2));
		if (pick < 7) return pixel_in_cell($urandom_range(DIM - 3, DIM - 1));
		return pixel_in_cell($urandom_range(6, 8));
	endfunction

	// ---------------------------------------------------------------------------------------
	// Tests.
	// ---------------------------------------------------------------------------------------

	// A full cell drops the fifth add; duplicate add and absent remove change nothing;
	// removal keeps the order of what is left.
	task automatic test_cell_capacity();
		logic signed [15:0] p;
		p = 16'(5 * 64 + 3);
		for (int i = 0; i < 5; i++) begin
			send_grid_op(ugns_pkg::OP_ADD, 16'(10 + i), p, p, 16'sd0, 16'sd0);
		end
		send_grid_op(ugns_pkg::OP_ADD, 16'd12, p, p, 16'sd0, 16'sd0);
		send_grid_op(ugns_pkg::OP_REMOVE, 16'd99, p, p, 16'sd0, 16'sd0);
		send_grid_op(ugns_pkg::OP_REMOVE, 16'd11, p, p, 16'sd0, 16'sd0);
		send_grid_op(ugns_pkg::OP_QUERY, 16'd0, p, p, 16'sd0, 16'sd0);
		send_grid_op(ugns_pkg::OP_ADD, 16'd15, p, p, 16'sd0, 16'sd0);
		send_grid_op(ugns_pkg::OP_MOVE, 16'd12, 16'(6 * 64), 16'(6 * 64), p, p);
		send_grid_op(ugns_pkg::OP_QUERY, 16'd0, p, p, 16'sd0, 16'sd0);
	endtask

	// Extreme coordinates clamp to the corners; extreme ids; queries in corners and walls.
	task automatic test_edges();
		send_grid_op(ugns_pkg::OP_ADD, 16'hffff, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0);
		send_grid_op(ugns_pkg::OP_ADD, 16'h0000, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0);
		send_grid_op(ugns_pkg::OP_ADD, 16'h5a5a, 16'sd32767, -16'sd1, 16'sd0, 16'sd0);
		send_grid_op(ugns_pkg::OP_ADD, 16'ha5a5, -16'sd63, 16'sd1000, 16'sd0, 16'sd0);
		send_grid_op(ugns_pkg::OP_QUERY, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_grid_op(ugns_pkg::OP_QUERY, 16'd0, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0);
		send_grid_op(ugns_pkg::OP_QUERY, 16'd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
		send_grid_op(ugns_pkg::OP_QUERY, 16'd0, 16'sd0, 16'sd960, 16'sd0, 16'sd0);
		send_grid_op(ugns_pkg::OP_QUERY, 16'd0, 16'sd64, 16'sd0, 16'sd0, 16'sd0);
		send_grid_op(ugns_pkg::OP_QUERY, 16'd0, 16'sd640, 16'sd640, 16'sd0, 16'sd0);
	endtask

	// Clear, then the unused operation codes, then a query of the emptied grid.
	task automatic test_clear_and_unused_codes();
		send_grid_op(ugns_pkg::OP_CLEAR, 16'hffff, 16'sd100, 16'sd100, 16'sd0, 16'sd0);
		for (int c = int'(ugns_pkg::OP_CLEAR) + 1; c < 8; c++) begin
			send_grid_op(3'(c), 16'h1234, 16'sd70, 16'sd70, 16'sd0, 16'sd0);
		end
		send_grid_op(ugns_pkg::OP_QUERY, 16'd0, 16'sd320, 16'sd320, 16'sd0, 16'sd0);
	endtask

	// Cell sizes at the extremes, including zero, which behaves as one.
	task automatic test_cell_sizes();
		int sizes [4] = '{1, 0, 8191, 4096};
		foreach (sizes[k]) begin
			write_cell_size(sizes[k]);
			send_grid_op(ugns_pkg::OP_ADD, 16'(k + 1), 16'sd7, 16'sd3, 16'sd0, 16'sd0);
			send_grid_op(ugns_pkg::OP_ADD, 16'(k + 40), 16'sd8, 16'sd4, 16'sd0, 16'sd0);
			send_grid_op(ugns_pkg::OP_QUERY, 16'd0, 16'sd7, 16'sd4, 16'sd0, 16'sd0);
		end
	endtask

	// The receiver refuses transfers for a long stretch while items keep coming, so the
	// output register fills and the block holds its input off.
	task automatic test_backpressure();
		write_cell_size(64);
		hold_req_seq++;
		for (int i = 0; i < 8; i++) begin
			send_grid_op(ugns_pkg::OP_ADD, 16'(200 + i), 16'(64 * (i % 3)), 16'sd64,
				16'sd0, 16'sd0);
		end
		send_grid_op(ugns_pkg::OP_QUERY, 16'd0, 16'sd64, 16'sd64, 16'sd0, 16'sd0);
	endtask

	// Random operations over several cell sizes. Most ids come from a small pool so that
	// duplicates, removals, moves and full cells happen often.
	task automatic test_random_ops();
		int sizes [5] = '{64, 7, 300, 4096, 1};
		int roll;
		int slot;
		logic [2:0] op;
		logic [15:0] id;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] ox;
		logic signed [15:0] oy;
		foreach (sizes[k]) begin
			write_cell_size((k == 2) ? $urandom_range(1, 4096) : sizes[k]);
			for (int j = 0; j < 15; j++) begin
				pool_x[j] = 16'sd0;
				pool_y[j] = 16'sd0;
			end
			for (int n = 0; n < 11; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 35) op = ugns_pkg::OP_ADD;
				else if (roll < 45) op = ugns_pkg::OP_REMOVE;
				else if (roll < 60) op = ugns_pkg::OP_MOVE;
				else if (roll < 94) op = ugns_pkg::OP_QUERY;
				else if (roll < 97) op = ugns_pkg::OP_CLEAR;
				else op = 3'($urandom_range(int'(ugns_pkg::OP_CLEAR) + 1, 7));
				slot = $urandom_range(0, 15);
				id = (slot == 15) ? 16'($urandom) : 16'(slot);
				px = random_coord();
				py = random_coord();
				ox = 16'($urandom);
				oy = 16'($urandom);
				if (slot < 15) begin
					if ((op == ugns_pkg::OP_MOVE || op == ugns_pkg::OP_REMOVE) &&
					    $urandom_range(0, 3) != 0) begin
						if (op == ugns_pkg::OP_MOVE) begin
							ox = pool_x[slot];
							oy = pool_y[slot];
						end else begin
							px = pool_x[slot];
							py = pool_y[slot];
						end
					end
					if (op == ugns_pkg::OP_ADD || op == ugns_pkg::OP_MOVE) begin
						pool_x[slot] = px;
						pool_y[slot] = py;
					end
				end
				send_grid_op(op, id, px, py, ox, oy);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		operation = '0;
		entity_id = '0;
		pos_x = '0;
		pos_y = '0;
		old_pos_x = '0;
		old_pos_y = '0;
		burst_left = 0;
		hold_req_seq = 0;
		cell_size = 64;
		for (int c = 0; c < DIM * DIM; c++) fill_count[c] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_cell_capacity();
		test_edges();
		test_clear_and_unused_codes();
		test_cell_sizes();
		test_backpressure();
		test_random_ops();
		drain_results();

		if (mismatches == 0) begin
			$display("uniform_grid_neighbour_store_core test passed");
		end else begin
			$display("uniform_grid_neighbour_store_core test failed");
		end
		$finish;
	end

endmodule
